>>> rtl/core/kde_pkg.sv
package kde_pkg;

    localparam int KDE_NUM_KEYS   = 12;
    localparam int KDE_THR_W      = 8;
    localparam int KDE_MAXD_W     = 4;
    localparam int KDE_CODE_W     = 4;
    localparam int KDE_MAG_W      = 32;
    localparam int KDE_QUIET_W    = 9;
    localparam int KDE_VALUE_W    = 31;
    localparam int KDE_CFG_IDX_W  = 1;
    localparam int KDE_CFG_DATA_W = 8;

    localparam logic KDE_OP_START  = 1'b0;
    localparam logic KDE_OP_SAMPLE = 1'b1;

    localparam logic [KDE_CFG_IDX_W-1:0] KDE_REG_THRESHOLD  = 1'b0;
    localparam logic [KDE_CFG_IDX_W-1:0] KDE_REG_MAX_DIGITS = 1'b1;

    localparam logic [KDE_CODE_W-1:0] KDE_KEY_NONE = 4'd0;
    localparam logic [KDE_CODE_W-1:0] KDE_KEY_ZERO = 4'd10;
    localparam logic [KDE_CODE_W-1:0] KDE_KEY_STAR = 4'd11;
    localparam logic [KDE_CODE_W-1:0] KDE_KEY_HASH = 4'd12;

    localparam logic [KDE_THR_W-1:0]  KDE_THR_RESET  = 8'd5;
    localparam logic [KDE_MAXD_W-1:0] KDE_MAXD_RESET = 4'd4;
    localparam logic [KDE_MAXD_W-1:0] KDE_MAXD_LIMIT = 4'd9;

    // reciprocal of ten, exact for any 32-bit dividend with a 35-bit shift
    localparam logic [KDE_MAG_W-1:0] KDE_RECIP10 = 32'hCCCC_CCCD;
    localparam int                   KDE_RECIP_SH = 35;

    // key bit index by priority, highest first
    localparam logic [3:0] KDE_KEY_ORDER [KDE_NUM_KEYS] =
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd10, 4'd9, 4'd11};

    typedef struct packed {
        logic [KDE_THR_W-1:0]  thr;
        logic [KDE_MAXD_W-1:0] max_digits;
    } t_cfg;

    typedef struct packed {
        logic signed [KDE_VALUE_W-1:0] entry_value;
        logic                          is_negative;
        logic                          display_changed;
        logic                          done_res;
        logic [KDE_CODE_W-1:0]         key_code;
        logic                          any_key;
    } t_result;

    function automatic logic [3:0] kde_digit(input logic [KDE_CODE_W-1:0] code);
        logic [3:0] d;
        d = (code == KDE_KEY_ZERO) ? 4'd0 : code;
        return d;
    endfunction

endpackage

>>> rtl/core/kde_in_if.sv
interface kde_in_if import kde_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    operation;
    logic [KDE_NUM_KEYS-1:0] key_levels;

    modport source (output valid, output operation, output key_levels, input ready);
    modport sink   (input valid, input operation, input key_levels, output ready);
endinterface

>>> rtl/core/kde_out_if.sv
interface kde_out_if import kde_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [KDE_VALUE_W-1:0] entry_value;
    logic                          is_negative;
    logic                          display_changed;
    logic                          done_res;
    logic [KDE_CODE_W-1:0]         key_code;
    logic                          any_key;

    modport source (output valid, output entry_value, output is_negative,
                    output display_changed, output done_res, output key_code,
                    output any_key, input ready);
    modport sink   (input valid, input entry_value, input is_negative,
                    input display_changed, input done_res, input key_code,
                    input any_key, output ready);
endinterface

>>> rtl/core/kde_lane.sv
module kde_lane import kde_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_clear,
    input  logic                 i_sample,
    input  logic                 i_level,
    input  logic [KDE_THR_W-1:0] i_thr,
    output logic                 o_down
);

    logic [KDE_THR_W-1:0] r_count;
    logic [KDE_THR_W-1:0] n_count;

    always_comb begin
        n_count = r_count;
        if (i_clear) begin
            n_count = '0;
        end else if (i_sample) begin
            if (!i_level) begin
                n_count = '0;
            end else if (r_count < i_thr) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    assign o_down = (n_count >= i_thr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

>>> rtl/core/kde_merge.sv
module kde_merge import kde_pkg::*; (
    input  logic [KDE_NUM_KEYS-1:0] i_down,
    output logic [KDE_CODE_W-1:0]   o_key
);

    // lowest priority first so the highest one wins
    always_comb begin
        o_key = KDE_KEY_NONE;
        for (int p = KDE_NUM_KEYS - 1; p >= 0; p--) begin
            if (i_down[KDE_KEY_ORDER[p]]) begin
                o_key = KDE_CODE_W'(p + 1);
            end
        end
    end

endmodule

>>> rtl/core/kde_entry.sv
module kde_entry import kde_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic                  i_op,
    input  logic [KDE_CODE_W-1:0] i_key,
    input  t_cfg                  i_cfg,
    output t_result               o_res
);

    logic [KDE_CODE_W-1:0]  r_prev,  n_prev;
    logic [KDE_MAG_W-1:0]   r_mag,   n_mag;
    logic [KDE_MAXD_W-1:0]  r_cnt,   n_cnt;
    logic                   r_neg,   n_neg;
    logic [KDE_QUIET_W-1:0] r_quiet, n_quiet;
    logic                   r_act,   n_act;

    logic [2*KDE_MAG_W-1:0] prod;
    logic [KDE_MAG_W-1:0]   quot;
    logic [KDE_MAG_W-1:0]   base;
    logic [KDE_MAG_W-1:0]   signed_mag;
    logic [KDE_MAXD_W-1:0]  limit;
    logic [KDE_CODE_W-1:0]  key;
    logic                   start;
    logic                   changed;
    logic                   done;

    assign start = (i_op == KDE_OP_START);
    assign key   = start ? KDE_KEY_NONE : i_key;
    assign prod  = {{KDE_MAG_W{1'b0}}, r_mag} * {{KDE_MAG_W{1'b0}}, KDE_RECIP10};
    assign quot  = KDE_MAG_W'(prod[2*KDE_MAG_W-1:KDE_RECIP_SH]);
    assign limit = (i_cfg.max_digits > KDE_MAXD_LIMIT) ? KDE_MAXD_LIMIT : i_cfg.max_digits;
    assign base  = (r_cnt >= limit) ? quot : r_mag;

    always_comb begin
        n_prev  = r_prev;
        n_mag   = r_mag;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        n_quiet = r_quiet;
        n_act   = r_act;
        changed = 1'b0;
        done    = 1'b0;
        if (start) begin
            n_prev  = KDE_KEY_NONE;
            n_mag   = '0;
            n_cnt   = '0;
            n_neg   = 1'b0;
            n_quiet = {1'b0, i_cfg.thr} + KDE_QUIET_W'(2);
            n_act   = 1'b1;
            changed = 1'b1;
        end else begin
            if (r_act && (r_quiet != '0)) begin
                n_quiet = r_quiet - 1'b1;
            end else if (r_act && (key != r_prev)) begin
                case (key)
                    KDE_KEY_HASH: begin
                        done  = 1'b1;
                        n_act = 1'b0;
                    end
                    KDE_KEY_STAR: begin
                        changed = 1'b1;
                        if (r_mag == '0) begin
                            n_neg = ~r_neg;
                        end else begin
                            if (r_cnt != '0) begin
                                n_cnt = r_cnt - 1'b1;
                            end
                            n_mag = quot;
                        end
                    end
                    KDE_KEY_NONE: begin
                        changed = 1'b1;
                    end
                    default: begin
                        changed = 1'b1;
                        if (r_cnt < limit) begin
                            n_cnt = r_cnt + 1'b1;
                        end
                        n_mag = {base[KDE_MAG_W-4:0], 3'b000} + {base[KDE_MAG_W-2:0], 1'b0}
                              + KDE_MAG_W'(kde_digit(key));
                    end
                endcase
            end
            n_prev = key;
        end
    end

    assign signed_mag = n_neg ? (KDE_MAG_W'(0) - n_mag) : n_mag;

    always_comb begin
        o_res.entry_value     = signed_mag[KDE_VALUE_W-1:0];
        o_res.is_negative     = n_neg;
        o_res.display_changed = changed;
        o_res.done_res        = done;
        o_res.key_code        = key;
        o_res.any_key         = (key != KDE_KEY_NONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= KDE_KEY_NONE;
            r_mag   <= '0;
            r_cnt   <= '0;
            r_neg   <= 1'b0;
            r_quiet <= '0;
            r_act   <= 1'b0;
        end else if (i_accept) begin
            r_prev  <= n_prev;
            r_mag   <= n_mag;
            r_cnt   <= n_cnt;
            r_neg   <= n_neg;
            r_quiet <= n_quiet;
            r_act   <= n_act;
        end
    end

endmodule

>>> rtl/core/keypad_debounce_number_entry_core.sv
// A request's result is registered into a two-entry output buffer when the request is accepted.
// Throughput: one request per cycle while the buffer has room; twelve counter lanes, the
// priority merge and the entry update all settle in the cycle of acceptance.
// Reset (synchronous, active low): run counters, entry state and buffer fill count cleared,
// threshold set to 5 and max digits to 4.
module keypad_debounce_number_entry_core import kde_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [KDE_CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [KDE_CFG_DATA_W-1:0] i_cfg_data,
    kde_in_if.sink                    i_req,
    kde_out_if.source                 o_rsp
);

    t_cfg                    r_cfg;
    logic [KDE_NUM_KEYS-1:0] down;
    logic [KDE_CODE_W-1:0]   key;
    t_result                 res;
    logic                    accept;
    logic                    sample;
    logic                    clear;

    t_result    r_slot0, n_slot0;
    t_result    r_slot1, n_slot1;
    logic [1:0] r_fill,  n_fill;
    logic [1:0] wr_idx;
    logic       pop;

    assign accept = i_req.valid && i_req.ready;
    assign sample = accept && (i_req.operation == KDE_OP_SAMPLE);
    assign clear  = accept && (i_req.operation == KDE_OP_START);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thr        <= KDE_THR_RESET;
            r_cfg.max_digits <= KDE_MAXD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                KDE_REG_THRESHOLD:  r_cfg.thr        <= i_cfg_data;
                KDE_REG_MAX_DIGITS: r_cfg.max_digits <= i_cfg_data[KDE_MAXD_W-1:0];
                default: ;
            endcase
        end
    end

    for (genvar k = 0; k < KDE_NUM_KEYS; k++) begin : g_lane
        kde_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_clear  (clear),
            .i_sample (sample),
            .i_level  (i_req.key_levels[k]),
            .i_thr    (r_cfg.thr),
            .o_down   (down[k])
        );
    end

    kde_merge u_merge (
        .i_down (down),
        .o_key  (key)
    );

    kde_entry u_entry (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_op     (i_req.operation),
        .i_key    (key),
        .i_cfg    (r_cfg),
        .o_res    (res)
    );

    // two-entry output buffer
    assign i_req.ready = (r_fill != 2'd2);
    assign pop         = (r_fill != 2'd0) && o_rsp.ready;
    assign wr_idx      = r_fill - {1'b0, pop};

    always_comb begin
        n_slot0 = r_slot0;
        n_slot1 = r_slot1;
        if (pop) begin
            n_slot0 = r_slot1;
        end
        if (accept) begin
            if (wr_idx == 2'd0) begin
                n_slot0 = res;
            end else begin
                n_slot1 = res;
            end
        end
        n_fill = r_fill + {1'b0, accept} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
        if (!i_rst_n) begin
            r_fill <= 2'd0;
        end else begin
            r_fill <= n_fill;
        end
    end

    assign o_rsp.valid           = (r_fill != 2'd0);
    assign o_rsp.entry_value     = r_slot0.entry_value;
    assign o_rsp.is_negative     = r_slot0.is_negative;
    assign o_rsp.display_changed = r_slot0.display_changed;
    assign o_rsp.done_res        = r_slot0.done_res;
    assign o_rsp.key_code        = r_slot0.key_code;
    assign o_rsp.any_key         = r_slot0.any_key;

`ifndef ASSERT_OFF
    a_done_no_redraw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.done_res) |-> !o_rsp.display_changed)
        else $error("done and display change reported together");

    a_any_key_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.any_key == (o_rsp.key_code != KDE_KEY_NONE)))
        else $error("any_key disagrees with key_code");

    a_fill_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !pop) |=> (r_fill == $past(r_fill) + 2'd1))
        else $error("output buffer lost a request");

    a_start_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (clear && (r_fill == 2'd0)) |=> (o_rsp.display_changed && !o_rsp.any_key))
        else $error("start result malformed");
`endif

endmodule

>>> tb/tb_keypad_debounce_number_entry_core.sv
module tb_keypad_debounce_number_entry_core import kde_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RESET_CYCLES = 10;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          DRAIN_CYCLES = 3;
    localparam int          END_CYCLES   = 6;
    localparam int          DECIMAL_BASE = 10;
    localparam int          KEY_BIT_STAR = 9;
    localparam int          KEY_BIT_ZERO = 10;
    localparam int          KEY_BIT_HASH = 11;
    localparam logic [11:0] LV_NONE      = 12'h000;
    localparam logic [11:0] LV_ALL       = 12'hFFF;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      cfg_we;
    logic [KDE_CFG_IDX_W-1:0]  cfg_idx;
    logic [KDE_CFG_DATA_W-1:0] cfg_data;

    kde_in_if  req_if ();
    kde_out_if rsp_if ();

    keypad_debounce_number_entry_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    // scanner/entry shadow state
    logic [KDE_THR_W-1:0]   cfg_thr;
    logic [KDE_MAXD_W-1:0]  cfg_maxd;
    logic [KDE_THR_W-1:0]   run_cnt [KDE_NUM_KEYS];
    logic [KDE_CODE_W-1:0]  last_code;
    logic [KDE_MAG_W-1:0]   mag;
    logic [3:0]             ndigits;
    logic                   neg;
    logic [KDE_QUIET_W-1:0] quiet_left;
    logic                   active;

    t_result     displays_due [$];
    int unsigned gap_pct;
    int unsigned stall_pct;
    int unsigned requests_sent;
    int unsigned fail_count;
    int unsigned cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic void clear_entry_state();
        for (int i = 0; i < KDE_NUM_KEYS; i++) begin
            run_cnt[i] = '0;
        end
        last_code  = KDE_KEY_NONE;
        mag        = '0;
        ndigits    = '0;
        neg        = 1'b0;
        quiet_left = '0;
        active     = 1'b0;
    endfunction

    function automatic t_result next_display(input logic op, input logic [11:0] lv);
        t_result               r;
        logic [KDE_CODE_W-1:0] code;
        logic                  chg;
        logic                  fin;
        logic [3:0]            lim;
        logic [KDE_MAG_W-1:0]  val;
        code = KDE_KEY_NONE;
        chg  = 1'b0;
        fin  = 1'b0;
        if (op == KDE_OP_START) begin
            clear_entry_state();
            active     = 1'b1;
            quiet_left = cfg_thr + 9'd2;
            chg        = 1'b1;
        end else begin
            for (int i = 0; i < KDE_NUM_KEYS; i++) begin
                if (lv[i]) begin
                    if (run_cnt[i] < cfg_thr) run_cnt[i] = run_cnt[i] + 1'b1;
                end else begin
                    run_cnt[i] = '0;
                end
            end
            // walk from lowest priority up so the highest one wins
            for (int p = KDE_NUM_KEYS - 1; p >= 0; p--) begin
                if (run_cnt[KDE_KEY_ORDER[p]] >= cfg_thr) code = KDE_CODE_W'(p + 1);
            end
            if (active && quiet_left != 0) begin
                quiet_left = quiet_left - 1'b1;
            end else if (active && code != last_code) begin
                if (code == KDE_KEY_HASH) begin
                    fin    = 1'b1;
                    active = 1'b0;
                end else if (code == KDE_KEY_STAR) begin
                    if (mag == 0) begin
                        neg = ~neg;
                    end else begin
                        if (ndigits != 0) ndigits = ndigits - 1'b1;
                        mag = mag / DECIMAL_BASE;
                    end
                    chg = 1'b1;
                end else if (code != KDE_KEY_NONE) begin
                    lim = (cfg_maxd > KDE_MAXD_LIMIT) ? KDE_MAXD_LIMIT : cfg_maxd;
                    if (ndigits >= lim) mag = mag / DECIMAL_BASE;
                    else ndigits = ndigits + 1'b1;
                    mag = mag * DECIMAL_BASE + (code % DECIMAL_BASE);
                    chg = 1'b1;
                end else begin
                    chg = 1'b1;
                end
            end
            last_code = code;
        end
        val               = neg ? (~mag + 1'b1) : mag;
        r.entry_value     = val[KDE_VALUE_W-1:0];
        r.is_negative     = neg;
        r.display_changed = chg;
        r.done_res        = fin;
        r.key_code        = code;
        r.any_key         = (code != KDE_KEY_NONE);
        return r;
    endfunction

    function automatic logic [11:0] key_mask(input int unsigned k);
        return 12'b1 << k;
    endfunction

    function automatic int unsigned pick_key_bit();
        int unsigned r;
        int unsigned d;
        r = $urandom_range(99);
        d = $urandom_range(9);
        if (r < 70) return (d == 9) ? KEY_BIT_ZERO : d;
        if (r < 88) return KEY_BIT_STAR;
        return KEY_BIT_HASH;
    endfunction

    task automatic set_idling(input int unsigned snd, input int unsigned rcv);
        gap_pct   = snd;
        stall_pct = rcv;
    endtask

    task automatic send_req(input logic op, input logic [11:0] lv);
        while ($urandom_range(99) < gap_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.operation  <= op;
        req_if.key_levels <= lv;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        displays_due.push_back(next_display(op, lv));
        requests_sent++;
    endtask

    task automatic scan(input logic [11:0] lv);
        send_req(KDE_OP_SAMPLE, lv);
    endtask

    task automatic start_entry();
        send_req(KDE_OP_START, 12'($urandom_range(4095)));
    endtask

    task automatic wait_idle();
        req_if.valid <= 1'b0;
        while (displays_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_register(input logic [KDE_CFG_IDX_W-1:0] idx,
                                input logic [KDE_CFG_DATA_W-1:0] data);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == KDE_REG_THRESHOLD) cfg_thr = data;
        else cfg_maxd = data[KDE_MAXD_W-1:0];
    endtask

    // bounce, hold around the threshold, then release
    task automatic press_key(input int unsigned k);
        logic [11:0] hold;
        int unsigned n;
        hold = key_mask(k);
        if ($urandom_range(99) < 15) hold |= key_mask($urandom_range(KDE_NUM_KEYS - 1));
        if ($urandom_range(99) < 30) begin
            repeat ($urandom_range(1, 3)) scan(hold & 12'($urandom_range(4095)));
        end
        n = cfg_thr + $urandom_range(0, 2);
        if (cfg_thr > 1 && $urandom_range(99) < 10) n = cfg_thr - 1;
        if (n == 0) n = 1;
        repeat (n) scan(hold);
        repeat ($urandom_range(1, 3)) scan(LV_NONE);
    endtask

    task automatic run_entry(input bit retune);
        start_entry();
        repeat (cfg_thr + 2) scan(12'($urandom_range(4095)));
        repeat ($urandom_range(1, 12)) begin
            if (retune && $urandom_range(99) < 5) begin
                set_register(KDE_REG_MAX_DIGITS, KDE_CFG_DATA_W'($urandom_range(15)));
            end
            press_key(pick_key_bit());
        end
        press_key(KEY_BIT_HASH);
    endtask

    task automatic run_random(input int unsigned budget, input bit retune);
        int unsigned first;
        int unsigned r;
        first = requests_sent;
        while (requests_sent - first < budget) begin
            r = $urandom_range(99);
            if (r < 8) begin
                repeat ($urandom_range(1, 4)) scan(12'($urandom_range(4095)));
            end else if (r < 11) begin
                start_entry();
            end else if (r < 13) begin
                wait_idle();
            end else begin
                run_entry(retune);
            end
        end
    endtask

    task automatic test_random_defaults();
        set_idling(0, 0);
        run_random(150, 1'b0);
    endtask

    task automatic test_directed_entry();
        set_idling(0, 0);
        set_register(KDE_REG_THRESHOLD, 8'd1);
        set_register(KDE_REG_MAX_DIGITS, 8'd2);
        start_entry();
        scan(LV_ALL);
        scan(LV_NONE);
        scan(LV_NONE);
        scan(key_mask(KEY_BIT_STAR));                         // sign flip on zero
        scan(key_mask(0));
        scan(key_mask(1));
        scan(key_mask(2));                                    // replaces last digit
        scan(key_mask(KEY_BIT_STAR) | key_mask(KEY_BIT_HASH)); // star outranks hash
        scan(key_mask(KEY_BIT_ZERO));
        scan(key_mask(3));
        scan(LV_NONE);
        scan(key_mask(KEY_BIT_HASH));
        scan(key_mask(KEY_BIT_STAR));                         // idle, no entry action
        scan(LV_ALL);
    endtask

    task automatic test_special_limits();
        set_idling(0, 0);
        // zero threshold: key one always reported
        set_register(KDE_REG_THRESHOLD, 8'd0);
        start_entry();
        repeat (3) scan(LV_NONE);
        set_register(KDE_REG_THRESHOLD, 8'd1);
        set_register(KDE_REG_MAX_DIGITS, 8'd0);
        start_entry();
        repeat (3) scan(LV_NONE);
        scan(key_mask(4));
        scan(LV_NONE);
        scan(key_mask(KEY_BIT_STAR));  // nonzero value with no digits counted
        scan(key_mask(6));
        set_register(KDE_REG_MAX_DIGITS, 8'd15);
        scan(key_mask(7));
        set_register(KDE_REG_MAX_DIGITS, 8'd1);
        scan(key_mask(8));
        scan(key_mask(KEY_BIT_HASH));
    endtask

    task automatic test_random_sender_idle();
        set_register(KDE_REG_THRESHOLD, 8'd1);
        set_register(KDE_REG_MAX_DIGITS, 8'd9);
        set_idling(59, 0);
        run_random(200, 1'b0);
    endtask

    task automatic test_random_receiver_stall();
        set_register(KDE_REG_THRESHOLD, 8'd2);
        set_register(KDE_REG_MAX_DIGITS, 8'd1);
        set_idling(0, 59);
        run_random(150, 1'b0);
    endtask

    task automatic test_random_both_idle();
        set_register(KDE_REG_THRESHOLD, 8'd3);
        set_register(KDE_REG_MAX_DIGITS, 8'd15);
        set_idling(10, 10);
        run_random(150, 1'b1);
    endtask

    task automatic test_zero_threshold_noise();
        set_register(KDE_REG_THRESHOLD, 8'd0);
        set_register(KDE_REG_MAX_DIGITS, KDE_CFG_DATA_W'($urandom_range(15)));
        set_idling(59, 59);
        start_entry();
        repeat (30) scan(12'($urandom_range(4095)));
    endtask

    task automatic test_long_threshold();
        set_register(KDE_REG_THRESHOLD, 8'd255);
        set_register(KDE_REG_MAX_DIGITS, 8'd9);
        set_idling(0, 0);
        start_entry();
        repeat (cfg_thr + 2) scan(12'($urandom_range(4095)));
        // digit and hash both saturate; digit wins, then hash once digit lifts
        repeat (cfg_thr) scan(key_mask(4) | key_mask(KEY_BIT_HASH));
        scan(key_mask(KEY_BIT_HASH));
        scan(LV_NONE);
    endtask

    task automatic compare_field(input string name, input logic signed [31:0] e,
                                 input logic signed [31:0] a);
        if (a !== e) begin
            $error("%s: expected %0d, got %0d", name, e, a);
            fail_count++;
        end
    endtask

    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (displays_due.size() == 0) begin
                $error("result with no request outstanding");
                fail_count++;
            end else begin
                e = displays_due.pop_front();
                compare_field("entry_value", $signed(e.entry_value), $signed(rsp_if.entry_value));
                compare_field("is_negative", e.is_negative, rsp_if.is_negative);
                compare_field("display_changed", e.display_changed, rsp_if.display_changed);
                compare_field("done_res", e.done_res, rsp_if.done_res);
                compare_field("key_code", e.key_code, rsp_if.key_code);
                compare_field("any_key", e.any_key, rsp_if.any_key);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        gap_pct           = 0;
        stall_pct         = 0;
        requests_sent     = 0;
        fail_count        = 0;
        cycle_count       = 0;
        cfg_thr           = KDE_THR_RESET;
        cfg_maxd          = KDE_MAXD_RESET;
        clear_entry_state();
        i_rst_n           <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_idx           <= KDE_REG_THRESHOLD;
        cfg_data          <= '0;
        req_if.valid      <= 1'b0;
        req_if.operation  <= KDE_OP_SAMPLE;
        req_if.key_levels <= LV_NONE;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_random_defaults();
        test_directed_entry();
        test_special_limits();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();
        test_zero_threshold_noise();
        test_long_threshold();

        wait_idle();
        repeat (END_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
